// ----- rtl/core/lrsc_pkg.sv -----
package lrsc_pkg;

  localparam int COORD_W            = 6;
  localparam int XOUT_W             = 7;
  localparam int COLOUR_W           = 8;
  localparam int CFG_W              = 7;
  localparam int CFG_IDX_W          = 2;
  localparam int DEFAULT_COORD_BITS = 6;
  localparam int STEP_W             = 3;

  localparam logic [CFG_W-1:0] CLIP_LEFT_RESET   = 7'd0;
  localparam logic [CFG_W-1:0] CLIP_TOP_RESET    = 7'd0;
  localparam logic [CFG_W-1:0] CLIP_RIGHT_RESET  = 7'd64;
  localparam logic [CFG_W-1:0] CLIP_BOTTOM_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_RIGHT  = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] left;
    logic [CFG_W-1:0] top;
    logic [CFG_W-1:0] right;
    logic [CFG_W-1:0] bottom;
  } clip_t;

  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_NOT_ACCEPT = 3'd1,
    C_ZERO       = 3'd2,
    C_NOT_HORIZ  = 3'd3,
    C_ROW_OUT    = 3'd4,
    C_OUT_TAKEN  = 3'd5,
    C_LAST_TAKEN = 3'd6
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_SORT   = 3'd1;
  localparam step_t STEP_KIND   = 3'd2;
  localparam step_t STEP_ROWCHK = 3'd3;
  localparam step_t STEP_SPAN   = 3'd4;
  localparam step_t STEP_LINE   = 3'd5;

  typedef struct packed {
    logic  take_in;
    logic  emit;
    logic  span_sel;
    logic  calc_span;
    logic  hold;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic accepted;
    logic zero_len;
    logic horiz;
    logic row_out;
    logic out_taken;
    logic at_end;
  } status_t;

  // Microprogram: a taken condition jumps to target, otherwise the step
  // counter holds or advances by one.
  function automatic ctrl_t program_word(step_t pc);
    ctrl_t w;
    w = '0;
    case (pc)
      STEP_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = C_NOT_ACCEPT;
        w.target  = STEP_WAIT;
      end
      STEP_SORT: begin
        w.calc_span = 1'b1;
        w.cond      = C_ZERO;
        w.target    = STEP_WAIT;
      end
      STEP_KIND: begin
        w.cond   = C_NOT_HORIZ;
        w.target = STEP_LINE;
      end
      STEP_ROWCHK: begin
        w.cond   = C_ROW_OUT;
        w.target = STEP_WAIT;
      end
      STEP_SPAN: begin
        w.emit     = 1'b1;
        w.span_sel = 1'b1;
        w.hold     = 1'b1;
        w.cond     = C_OUT_TAKEN;
        w.target   = STEP_WAIT;
      end
      STEP_LINE: begin
        w.emit   = 1'b1;
        w.hold   = 1'b1;
        w.cond   = C_LAST_TAKEN;
        w.target = STEP_WAIT;
      end
      default: begin
        w.cond   = C_NEVER;
        w.target = STEP_WAIT;
        w.hold   = 1'b0;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/lrsc_if.sv -----
interface lrsc_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [lrsc_pkg::COORD_W-1:0]     start_x;
  logic [lrsc_pkg::COORD_W-1:0]     start_y;
  logic [lrsc_pkg::COORD_W-1:0]     end_x;
  logic [lrsc_pkg::COORD_W-1:0]     end_y;
  logic [lrsc_pkg::COLOUR_W-1:0]    red;
  logic [lrsc_pkg::COLOUR_W-1:0]    green;
  logic [lrsc_pkg::COLOUR_W-1:0]    blue;

  modport source (output valid, start_x, start_y, end_x, end_y, red, green, blue,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, red, green, blue,
                output ready);
endinterface

interface lrsc_pix_if;
  logic                             valid;
  logic                             ready;
  logic [lrsc_pkg::XOUT_W-1:0]      pixel_x;
  logic [lrsc_pkg::COORD_W-1:0]     pixel_y;
  logic [lrsc_pkg::XOUT_W-1:0]      span_last_x;
  logic [lrsc_pkg::COLOUR_W-1:0]    out_red;
  logic [lrsc_pkg::COLOUR_W-1:0]    out_green;
  logic [lrsc_pkg::COLOUR_W-1:0]    out_blue;
  logic                             last;

  modport source (output valid, pixel_x, pixel_y, span_last_x, out_red, out_green,
                  out_blue, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, span_last_x, out_red, out_green,
                out_blue, last, output ready);
endinterface

// ----- rtl/core/line_rasterizer_with_span_clip.sv -----
// Channel     Role   Beat contents
// line_in     sink   start_x, start_y, end_x, end_y, red, green, blue
// pixel_out   source pixel_x, pixel_y, span_last_x, out_red, out_green, out_blue, last
// write port  in     write_en, write_index, write_data (clip registers)
//
// A command is taken in the wait step, then the sort, kind and row-check steps classify it.
// A stepped line gives one pixel beat per cycle while pixel_out is ready.
// A zero-length line stops after sort, a sloped line goes from kind to stepping, and a
// horizontal span is sent as one beat, or dropped when its row lies outside the clip.
// The rate is set by the microprogram sequencer, which works on one command at a time.
// Reset is synchronous; it returns the sequencer to wait and restores the clip registers.
// A stalled pixel_out holds the current beat and all line state.
module line_rasterizer_with_span_clip #(
  parameter int COORD_BITS = lrsc_pkg::DEFAULT_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  lrsc_cmd_if.sink                       line_in,
  lrsc_pix_if.source                     pixel_out,
  input  logic                           write_en,
  input  logic [lrsc_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [lrsc_pkg::CFG_W-1:0]     write_data
);

  lrsc_pkg::clip_t   clip;
  lrsc_pkg::ctrl_t   ctrl;
  lrsc_pkg::status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip.left   <= lrsc_pkg::CLIP_LEFT_RESET;
      clip.top    <= lrsc_pkg::CLIP_TOP_RESET;
      clip.right  <= lrsc_pkg::CLIP_RIGHT_RESET;
      clip.bottom <= lrsc_pkg::CLIP_BOTTOM_RESET;
    end else if (write_en) begin
      case (write_index)
        lrsc_pkg::CFG_CLIP_LEFT:   clip.left   <= write_data;
        lrsc_pkg::CFG_CLIP_TOP:    clip.top    <= write_data;
        lrsc_pkg::CFG_CLIP_RIGHT:  clip.right  <= write_data;
        lrsc_pkg::CFG_CLIP_BOTTOM: clip.bottom <= write_data;
        default: begin
        end
      endcase
    end
  end

  lrsc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  lrsc_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .clip      (clip),
    .st        (st),
    .line_in   (line_in),
    .pixel_out (pixel_out)
  );

endmodule

// ----- rtl/core/lrsc_seq.sv -----
module lrsc_seq (
  input  logic              clk,
  input  logic              rst,
  input  lrsc_pkg::status_t st,
  output lrsc_pkg::ctrl_t   ctrl
);

  lrsc_pkg::step_t pc;
  lrsc_pkg::step_t pc_next;
  logic            jump;

  assign ctrl = lrsc_pkg::program_word(pc);

  always_comb begin
    case (ctrl.cond)
      lrsc_pkg::C_NEVER:      jump = 1'b0;
      lrsc_pkg::C_NOT_ACCEPT: jump = !st.accepted;
      lrsc_pkg::C_ZERO:       jump = st.zero_len;
      lrsc_pkg::C_NOT_HORIZ:  jump = !st.horiz;
      lrsc_pkg::C_ROW_OUT:    jump = st.row_out;
      lrsc_pkg::C_OUT_TAKEN:  jump = st.out_taken;
      lrsc_pkg::C_LAST_TAKEN: jump = st.out_taken && st.at_end;
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_next = ctrl.target;
    end else if (ctrl.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lrsc_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_sort: assert property (@(posedge clk) disable iff (rst)
    st.accepted |=> pc == lrsc_pkg::STEP_SORT)
    else $error("accepted command did not move to the sort step");

  a_last_to_wait: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && st.out_taken && (st.at_end || ctrl.span_sel)) |=>
      (pc == lrsc_pkg::STEP_WAIT))
    else $error("final beat did not return the sequencer to wait");
`endif

endmodule

// ----- rtl/core/lrsc_dp.sv -----
module lrsc_dp #(
  parameter int COORD_BITS = lrsc_pkg::DEFAULT_COORD_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  lrsc_pkg::ctrl_t   ctrl,
  input  lrsc_pkg::clip_t   clip,
  output lrsc_pkg::status_t st,
  lrsc_cmd_if.sink          line_in,
  lrsc_pix_if.source        pixel_out
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int FW = COORD_BITS + 3;
  localparam int XW = lrsc_pkg::XOUT_W;
  localparam int YW = lrsc_pkg::COORD_W;
  localparam int CW = lrsc_pkg::COLOUR_W;

  function automatic logic [XW-1:0] clamp_col(logic [XW-1:0] e, lrsc_pkg::clip_t c);
    logic [XW-1:0] v;
    v = (e > c.right) ? c.right : e;
    v = (v < c.left) ? c.left : v;
    return v;
  endfunction

  logic [CB-1:0]        x0_in, y0_in, x1_in, y1_in;
  logic [CB-1:0]        adx, ady;
  logic                 major_in;
  logic signed [FW-1:0] frac_init;

  logic [CB-1:0]        x, y, x1, y1;
  logic                 neg_x, neg_y, major_x, zero_len, horiz;
  logic [DW-1:0]        dx2, dy2;
  logic signed [FW-1:0] frac;
  logic [CW-1:0]        red, green, blue;
  logic [XW-1:0]        span_a, span_b;

  logic                 accepted, advance, frac_nonneg, at_end;
  logic [CB-1:0]        x_step, y_step;
  logic signed [FW-1:0] d_major, d_minor, frac_next;
  logic [XW-1:0]        lo_col, hi_col;

  assign x0_in = line_in.start_x[CB-1:0];
  assign y0_in = line_in.start_y[CB-1:0];
  assign x1_in = line_in.end_x[CB-1:0];
  assign y1_in = line_in.end_y[CB-1:0];

  assign adx      = (x1_in >= x0_in) ? x1_in - x0_in : x0_in - x1_in;
  assign ady      = (y1_in >= y0_in) ? y1_in - y0_in : y0_in - y1_in;
  assign major_in = adx > ady;

  always_comb begin
    if (major_in) begin
      frac_init = signed'({2'b00, ady, 1'b0}) - signed'({3'b000, adx});
    end else begin
      frac_init = signed'({2'b00, adx, 1'b0}) - signed'({3'b000, ady});
    end
  end

  assign accepted    = line_in.valid && line_in.ready;
  assign advance     = ctrl.emit && !ctrl.span_sel && pixel_out.ready;
  assign frac_nonneg = !frac[FW-1];
  assign at_end      = major_x ? (x == x1) : (y == y1);

  assign x_step = neg_x ? x - 1'b1 : x + 1'b1;
  assign y_step = neg_y ? y - 1'b1 : y + 1'b1;

  assign d_major   = major_x ? signed'({2'b00, dx2}) : signed'({2'b00, dy2});
  assign d_minor   = major_x ? signed'({2'b00, dy2}) : signed'({2'b00, dx2});
  assign frac_next = frac + d_minor - (frac_nonneg ? d_major : '0);

  assign lo_col = neg_x ? XW'(x1) : XW'(x);
  assign hi_col = neg_x ? XW'(x) : XW'(x1);

  always_ff @(posedge clk) begin
    if (accepted) begin
      x        <= x0_in;
      y        <= y0_in;
      x1       <= x1_in;
      y1       <= y1_in;
      neg_x    <= x1_in < x0_in;
      neg_y    <= y1_in < y0_in;
      major_x  <= major_in;
      zero_len <= (adx == '0) && (ady == '0);
      horiz    <= ady == '0;
      dx2      <= {adx, 1'b0};
      dy2      <= {ady, 1'b0};
      frac     <= frac_init;
      red      <= line_in.red;
      green    <= line_in.green;
      blue     <= line_in.blue;
    end else if (advance) begin
      frac <= frac_next;
      if (major_x) begin
        x <= x_step;
        if (frac_nonneg) begin
          y <= y_step;
        end
      end else begin
        y <= y_step;
        if (frac_nonneg) begin
          x <= x_step;
        end
      end
    end
    if (ctrl.calc_span) begin
      span_a <= clamp_col(lo_col, clip);
      span_b <= clamp_col(hi_col, clip);
    end
  end

  assign line_in.ready = ctrl.take_in;

  assign pixel_out.valid       = ctrl.emit;
  assign pixel_out.pixel_x     = ctrl.span_sel ? span_a : XW'(x);
  assign pixel_out.pixel_y     = YW'(y);
  assign pixel_out.span_last_x = ctrl.span_sel ? span_b : XW'(x);
  assign pixel_out.out_red     = red;
  assign pixel_out.out_green   = green;
  assign pixel_out.out_blue    = blue;
  assign pixel_out.last        = ctrl.span_sel || at_end;

  assign st.accepted  = accepted;
  assign st.zero_len  = zero_len;
  assign st.horiz     = horiz;
  assign st.row_out   = (XW'(y) >= clip.bottom) || (XW'(y) < clip.top);
  assign st.out_taken = ctrl.emit && pixel_out.ready;
  assign st.at_end    = at_end;

`ifndef ASSERT_OFF
  a_major_moves: assert property (@(posedge clk) disable iff (rst)
    advance |=> (major_x ? (x != $past(x)) : (y != $past(y))))
    else $error("major coordinate did not move on a stepped beat");

  a_minor_moves: assert property (@(posedge clk) disable iff (rst)
    (advance && frac_nonneg) |=> (major_x ? (y != $past(y)) : (x != $past(x))))
    else $error("minor coordinate did not move when the error term was non-negative");
`endif

endmodule
